// ----- rtl/ct_pkg.sv -----
// ----------------------------------------------------------------------------
// ct_pkg
// shared types, codes and constants of the character stream tokeniser
// ----------------------------------------------------------------------------
package ct_pkg;

  // field widths fixed by the token format
  localparam int CHAR_W  = 8;
  localparam int KIND_W  = 3;
  localparam int TOKEN_W = 16;

  // default width of the internal offset and length counters
  localparam int OFFSET_BITS_DEF = 16;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // input command codes
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_INT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FLOAT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OP    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_IDENT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END   = 3'd4;

  // character classes found by the front
  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_DIGIT,
    CLS_DOT,
    CLS_ALPHA,
    CLS_OP
  } char_class_t;

  // special characters
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

  // one classified transaction, as queued between front and back
  typedef struct packed {
    logic              is_end;
    char_class_t       cls;
    logic [CHAR_W-1:0] op_char;
  } queue_entry_t;

endpackage

// ----- rtl/ct_char_if.sv -----
// ----------------------------------------------------------------------------
// ct_char_if
// source character channel: valid/ready handshake with command and byte
// ----------------------------------------------------------------------------
interface ct_char_if;
  import ct_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [CHAR_W-1:0] char_byte;

  modport source (output valid, output cmd, output char_byte, input ready);
  modport sink   (input valid, input cmd, input char_byte, output ready);
endinterface

// ----------------------------------------------------------------------------
// ct_token_if
// token channel: valid/ready handshake with kind, start, length, operator
// ----------------------------------------------------------------------------
interface ct_token_if;
  import ct_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  token_kind;
  logic [TOKEN_W-1:0] token_start;
  logic [TOKEN_W-1:0] token_length;
  logic [CHAR_W-1:0]  operator_char;
  logic               last;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output operator_char, output last,
                  input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input operator_char, input last,
                  output ready);
endinterface

// ----- rtl/ct_queue.sv -----
// ----------------------------------------------------------------------------
// ct_queue
// short register queue of classified transactions between front and back
// ----------------------------------------------------------------------------
module ct_queue #(
  parameter int DEPTH = ct_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ct_pkg::queue_entry_t push_entry,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output ct_pkg::queue_entry_t head
);
  import ct_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  queue_entry_t     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ----- rtl/ct_front.sv -----
// ----------------------------------------------------------------------------
// ct_front
// accepts source transactions and classifies each character for the back
// ----------------------------------------------------------------------------
module ct_front (
  ct_char_if.sink              chars,
  input  logic                 queue_full,
  output logic                 push,
  output ct_pkg::queue_entry_t push_entry
);
  import ct_pkg::*;

  function automatic char_class_t classify(input logic [CHAR_W-1:0] c);
    char_class_t cls;
    cls = CLS_OTHER;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      cls = CLS_DIGIT;
    end else if (c == CH_DOT) begin
      cls = CLS_DOT;
    end else if ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z)) begin
      cls = CLS_ALPHA;
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
      cls = CLS_OP;
    end
    return cls;
  endfunction

  assign chars.ready = !queue_full;
  assign push        = chars.valid && !queue_full;

  always_comb begin
    push_entry.is_end  = (chars.cmd == CMD_END);
    push_entry.cls     = classify(chars.char_byte);
    push_entry.op_char = chars.char_byte;
  end
endmodule

// ----- rtl/ct_back.sv -----
// ----------------------------------------------------------------------------
// ct_back
// scan state machine: extends, closes and emits tokens into an output register
// ----------------------------------------------------------------------------
module ct_back #(
  parameter int OFFSET_BITS = ct_pkg::OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 entry_valid,
  input  ct_pkg::queue_entry_t entry,
  output logic                 entry_pop,
  ct_token_if.source           tokens
);
  import ct_pkg::*;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_NUM   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;

  localparam logic [OFFSET_BITS-1:0] LEN_MAX = '1;
  localparam logic [OFFSET_BITS-1:0] LEN_ONE = OFFSET_BITS'(1);

  // scan state
  logic [1:0]             scan_mode;
  logic                   seen_dot;
  logic [OFFSET_BITS-1:0] pending_start;
  logic [OFFSET_BITS-1:0] pending_length;
  logic [OFFSET_BITS-1:0] char_position;
  logic                   phase;

  // output register
  logic               out_valid;
  logic [KIND_W-1:0]  out_kind;
  logic [TOKEN_W-1:0] out_start;
  logic [TOKEN_W-1:0] out_length;
  logic [CHAR_W-1:0]  out_op;
  logic               out_last;

  logic               is_digit, is_dot, is_alpha, is_op;
  logic               extend, closing, has_second, two, emit;
  logic               out_free, go, finish, sel_pending;
  logic [KIND_W-1:0]  res_kind;
  logic [TOKEN_W-1:0] res_start;
  logic [TOKEN_W-1:0] res_length;
  logic [CHAR_W-1:0]  res_op;
  logic               res_last;

  always_comb begin
    is_digit = !entry.is_end && (entry.cls == CLS_DIGIT);
    is_dot   = !entry.is_end && (entry.cls == CLS_DOT);
    is_alpha = !entry.is_end && (entry.cls == CLS_ALPHA);
    is_op    = !entry.is_end && (entry.cls == CLS_OP);

    extend = ((scan_mode == MODE_NUM) && (is_digit || is_dot)) ||
             ((scan_mode == MODE_IDENT) && (is_digit || is_alpha));
    closing    = !extend && (scan_mode != MODE_IDLE);
    has_second = entry.is_end || is_op;
    two        = closing && has_second;
    emit       = closing || has_second;

    out_free = !out_valid || tokens.ready;
    go       = entry_valid && (!emit || out_free);
    finish   = go && !(two && !phase);

    // pending token goes first, the end or operator token second
    sel_pending = closing && !phase;
    res_last    = !(two && !phase);
    if (sel_pending) begin
      res_kind   = (scan_mode == MODE_IDENT) ? KIND_IDENT
                 : (seen_dot ? KIND_FLOAT : KIND_INT);
      res_start  = TOKEN_W'(pending_start);
      res_length = TOKEN_W'(pending_length);
      res_op     = '0;
    end else begin
      res_kind   = entry.is_end ? KIND_END : KIND_OP;
      res_start  = TOKEN_W'(char_position);
      res_length = entry.is_end ? '0 : TOKEN_W'(1);
      res_op     = entry.is_end ? '0 : entry.op_char;
    end
  end

  assign entry_pop            = finish;
  assign tokens.valid         = out_valid;
  assign tokens.token_kind    = out_kind;
  assign tokens.token_start   = out_start;
  assign tokens.token_length  = out_length;
  assign tokens.operator_char = out_op;
  assign tokens.last          = out_last;

  always_ff @(posedge clk) begin
    if (go && emit && out_free) begin
      out_kind   <= res_kind;
      out_start  <= res_start;
      out_length <= res_length;
      out_op     <= res_op;
      out_last   <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      phase          <= 1'b0;
      scan_mode      <= MODE_IDLE;
      seen_dot       <= 1'b0;
      pending_start  <= '0;
      pending_length <= '0;
      char_position  <= '0;
    end else begin
      if (go && emit) begin
        out_valid <= 1'b1;
      end else if (tokens.ready) begin
        out_valid <= 1'b0;
      end
      if (go) begin
        phase <= two && !phase;
      end
      if (finish) begin
        if (entry.is_end) begin
          scan_mode      <= MODE_IDLE;
          seen_dot       <= 1'b0;
          pending_start  <= '0;
          pending_length <= '0;
          char_position  <= '0;
        end else begin
          char_position <= char_position + 1'b1;
          if (extend) begin
            if (is_dot) begin
              seen_dot <= 1'b1;
            end
            if (pending_length != LEN_MAX) begin
              pending_length <= pending_length + 1'b1;
            end
          end else if (is_digit || is_alpha) begin
            scan_mode      <= is_digit ? MODE_NUM : MODE_IDENT;
            seen_dot       <= 1'b0;
            pending_start  <= char_position;
            pending_length <= LEN_ONE;
          end else begin
            scan_mode      <= MODE_IDLE;
            seen_dot       <= 1'b0;
            pending_start  <= '0;
            pending_length <= '0;
          end
        end
      end
    end
  end
endmodule

// ----- rtl/char_stream_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// char_stream_tokenizer_top
// character stream tokeniser for numbers, identifiers and operators
// ----------------------------------------------------------------------------
// usage
//   chars  : one transaction per source character (cmd char) or end of source
//            (cmd end); accepted when valid and ready are both high
//   tokens : one transaction per token, kind / start offset / length /
//            operator byte, with last set on the final token of an input
//   path   : the input transaction that completes a token is written into the
//            queue, and the token is then registered in the output register
//   rate   : one input per cycle unless the queue is full; an input causing
//            two tokens (a pending token closed by an operator or by end of
//            source) is held until both enter the single output register
//   the two-entry queue between front and back keeps input ready high while
//   a token waits on a stalled receiver; when the queue fills, ready drops
//   reset  : synchronous; clears the queue, the output valid flag, the scan
//            mode and the character position
//   offsets wrap at 2^OFFSET_BITS, lengths saturate at 2^OFFSET_BITS - 1
// ----------------------------------------------------------------------------
module char_stream_tokenizer_top #(
  parameter int OFFSET_BITS = ct_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ct_char_if.sink     chars,
  ct_token_if.source  tokens
);
  import ct_pkg::*;

  // front to queue
  logic         push;
  queue_entry_t push_entry;
  logic         queue_full;

  // queue to back
  logic         pop;
  logic         queue_not_empty;
  queue_entry_t head;

  // front: handshake and character classification
  ct_front u_front (
    .chars      (chars),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue, lets front and back stall independently
  ct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (queue_not_empty),
    .head       (head)
  );

  // back: scan state and token output register
  ct_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (queue_not_empty),
    .entry       (head),
    .entry_pop   (pop),
    .tokens      (tokens)
  );
endmodule

// ----- rtl/ct_checker.sv -----
// ----------------------------------------------------------------------------
// ct_checker
// port-level checks of the tokeniser, bound to the top level
// ----------------------------------------------------------------------------
module ct_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ct_pkg::KIND_W-1:0]  out_kind,
  input logic [ct_pkg::TOKEN_W-1:0] out_length,
  input logic [ct_pkg::CHAR_W-1:0]  out_op,
  input logic                       out_last
);
  import ct_pkg::*;

  // stalled token transaction keeps its kind and length
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_length))
    else $error("token changed while stalled");

  // end token is empty and closes its input
  a_end_token: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_END |-> out_length == '0 && out_op == '0 && out_last)
    else $error("malformed end token");

  // operator token is one character and always the final token of its input
  a_op_token: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_OP |-> out_length == TOKEN_W'(1) && out_last)
    else $error("malformed operator token");

  // nothing is shown in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("token valid after reset");
endmodule

bind char_stream_tokenizer_top ct_checker u_ct_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (tokens.valid),
  .out_ready  (tokens.ready),
  .out_kind   (tokens.token_kind),
  .out_length (tokens.token_length),
  .out_op     (tokens.operator_char),
  .out_last   (tokens.last)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the character stream tokeniser: a queue of source
// characters feeds a bursty driver, a scoring model predicts every token and
// a stalling monitor checks each token transaction against it in order
// ----------------------------------------------------------------------------
module tb;
  import ct_pkg::*;

  // minimum number of random source items after the directed and long-token parts
  localparam int RANDOM_ITEMS = 1500;
  // characters appended after the first letter of the long identifier,
  // far longer than any of the random tokens
  localparam int LONG_TAIL    = 300;
  // the receiver holds off once each of these cycle counts after reset is reached
  localparam int HOLD_AT_A    = 300;
  localparam int HOLD_AT_B    = 1500;
  localparam int HOLD_LEN     = 300;
  // cycles without any transaction before the run is declared hung
  localparam int STALL_LIMIT  = 2000;
  // settling time once every expected token has arrived
  localparam int DRAIN_CYCLES = 20;

  // what the random generator asks for
  typedef enum int {PICK_DIGIT, PICK_LETTER, PICK_OP} char_pick_t;

  // token scanning state of the scoring model
  typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_WORD} scan_state_t;

  typedef struct packed {
    logic              cmd;
    logic [CHAR_W-1:0] ch;
  } src_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TOKEN_W-1:0] start;
    logic [TOKEN_W-1:0] length;
    logic [CHAR_W-1:0]  op_char;
    logic               last;
  } token_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ct_char_if  chars_bus ();
  ct_token_if tokens_bus ();

  char_stream_tokenizer_top dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_bus),
    .tokens (tokens_bus)
  );

  always #10 clk = ~clk;

  // pending source items and the tokens the model says must come out
  src_item_t source_chars[$];
  token_t    expected_tokens[$];

  // scoring model state
  scan_state_t        scan_state = SCAN_IDLE;
  logic               dot_seen = 1'b0;
  logic [TOKEN_W-1:0] word_start = '0;
  logic [TOKEN_W-1:0] word_len = '0;
  logic [TOKEN_W-1:0] char_pos = '0;

  int error_count = 0;
  int tokens_seen = 0;
  int idle_cycles = 0;

  // driver bookkeeping
  src_item_t next_item;
  int        burst_left = 0;
  int        gap_left = 0;

  // monitor bookkeeping
  token_t got_token;
  token_t want_token;
  int     rx_phase = 0;
  int     stall_pct = 0;

  // long hold-off bookkeeping
  int hold_left;
  int run_cycles;

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic token_t make_token(input logic [KIND_W-1:0] kind,
                                        input logic [TOKEN_W-1:0] start,
                                        input logic [TOKEN_W-1:0] length,
                                        input logic [CHAR_W-1:0] op_char);
    token_t t;
    t = '{kind: kind, start: start, length: length, op_char: op_char, last: 1'b0};
    return t;
  endfunction

  // append a predicted token at the tail of the scoreboard
  function automatic void expect_token(input token_t t);
    expected_tokens.insert(expected_tokens.size(), t);
  endfunction

  // emit the word in progress, if any, and fall back to idle
  function automatic void close_word();
    if (scan_state == SCAN_NUMBER)
      expect_token(make_token(dot_seen ? KIND_FLOAT : KIND_INT, word_start, word_len, '0));
    else if (scan_state == SCAN_WORD)
      expect_token(make_token(KIND_IDENT, word_start, word_len, '0));
    scan_state = SCAN_IDLE;
    dot_seen   = 1'b0;
    word_start = '0;
    word_len   = '0;
  endfunction

  // advance the model by one accepted source transaction
  function automatic void tokenise_item(input logic cmd, input logic [CHAR_W-1:0] ch);
    int                 queued_n;
    logic               is_digit;
    logic               is_alpha;
    logic               is_op;
    logic [TOKEN_W-1:0] pos;
    queued_n = expected_tokens.size();
    pos      = char_pos;
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_alpha = ((ch >= CH_UP_A) && (ch <= CH_UP_Z)) || ((ch >= CH_LO_A) && (ch <= CH_LO_Z));
    is_op    = (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR) || (ch == CH_SLASH);
    if (cmd == CMD_END) begin
      close_word();
      expect_token(make_token(KIND_END, pos, '0, '0));
      char_pos = '0;
    end else begin
      if ((scan_state == SCAN_NUMBER && (is_digit || ch == CH_DOT)) ||
          (scan_state == SCAN_WORD && (is_digit || is_alpha))) begin
        if (ch == CH_DOT)
          dot_seen = 1'b1;
        // length sticks at the ceiling
        if (word_len != {TOKEN_W{1'b1}})
          word_len = word_len + 1'b1;
      end else begin
        // a character that ends a word is then treated as if nothing were pending
        close_word();
        if (is_digit) begin
          scan_state = SCAN_NUMBER;
          word_start = pos;
          word_len   = TOKEN_W'(1);
        end else if (is_op) begin
          expect_token(make_token(KIND_OP, pos, TOKEN_W'(1), ch));
        end else if (is_alpha) begin
          scan_state = SCAN_WORD;
          word_start = pos;
          word_len   = TOKEN_W'(1);
        end
      end
      char_pos = pos + 1'b1;
    end
    if (expected_tokens.size() > queued_n)
      expected_tokens[expected_tokens.size()-1].last = 1'b1;
  endfunction

  task automatic add_item(input logic cmd, input logic [CHAR_W-1:0] ch);
    src_item_t it;
    it = '{cmd: cmd, ch: ch};
    source_chars.insert(source_chars.size(), it);
  endtask

  task automatic add_text(input string s);
    foreach (s[i])
      add_item(CMD_CHAR, s[i]);
  endtask

  function automatic logic [CHAR_W-1:0] random_byte();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CHAR_W-1:0] random_char(input char_pick_t pick);
    logic [CHAR_W-1:0] c;
    case (pick)
      PICK_DIGIT: c = CH_ZERO + CHAR_W'($urandom_range(0, 9));
      PICK_LETTER: c = ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) +
                       CHAR_W'($urandom_range(0, 25));
      default: begin
        case ($urandom_range(0, 3))
          0: c = CH_PLUS;
          1: c = CH_MINUS;
          2: c = CH_STAR;
          default: c = CH_SLASH;
        endcase
      end
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // driver: offers queued items in bursts separated by random gaps; the model
  // is advanced on the edge at which a transaction is accepted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      chars_bus.valid     <= 1'b0;
      chars_bus.cmd       <= CMD_CHAR;
      chars_bus.char_byte <= '0;
    end else begin
      if (chars_bus.valid && chars_bus.ready)
        tokenise_item(chars_bus.cmd, chars_bus.char_byte);
      // only move on once the current item has gone (or none is offered)
      if (!chars_bus.valid || chars_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          chars_bus.valid <= 1'b0;
        end else if (source_chars.size() > 0) begin
          next_item = source_chars.pop_front();
          chars_bus.valid     <= 1'b1;
          chars_bus.cmd       <= next_item.cmd;
          chars_bus.char_byte <= next_item.ch;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // a quarter of the bursts run straight into the next one
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          chars_bus.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // long hold-offs: timed in cycles from the end of reset, so the block
  // backs up its input while the driver keeps offering
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      run_cycles <= 0;
      hold_left  <= 0;
    end else begin
      run_cycles <= run_cycles + 1;
      if (run_cycles == HOLD_AT_A || run_cycles == HOLD_AT_B)
        hold_left <= HOLD_LEN;
      else if (hold_left > 0)
        hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks every token transaction against the oldest prediction;
  // ready follows a stall rate redrawn each time rx_phase wraps, and twice the
  // receiver holds off for a long stretch so the block backs up its input
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      tokens_bus.ready <= 1'b0;
    end else begin
      if (tokens_bus.valid && tokens_bus.ready) begin
        got_token = '{kind: tokens_bus.token_kind, start: tokens_bus.token_start,
                      length: tokens_bus.token_length, op_char: tokens_bus.operator_char,
                      last: tokens_bus.last};
        if (expected_tokens.size() == 0) begin
          report_error($sformatf("unexpected token kind %0d start %0d len %0d op %02h last %0b",
                                 got_token.kind, got_token.start, got_token.length,
                                 got_token.op_char, got_token.last));
        end else begin
          want_token = expected_tokens.pop_front();
          if (got_token !== want_token)
            report_error($sformatf({"token %0d: got kind %0d start %0d len %0d op %02h ",
                                    "last %0b, want kind %0d start %0d len %0d op %02h last %0b"},
                                   tokens_seen, got_token.kind, got_token.start,
                                   got_token.length, got_token.op_char, got_token.last,
                                   want_token.kind, want_token.start, want_token.length,
                                   want_token.op_char, want_token.last));
        end
        tokens_seen++;
      end
      if (rx_phase == 0)
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      rx_phase = (rx_phase + 1) % 64;
      if (hold_left > 0) begin
        tokens_bus.ready <= 1'b0;
      end else begin
        tokens_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // watchdog: a hung block shows as a long run of cycles with no transaction
  always @(posedge clk) begin
    if (rst || (chars_bus.valid && chars_bus.ready) ||
        (tokens_bus.valid && tokens_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int base_n;
    int run_len;

    // directed: a float closed by an operator (two tokens in one step), an
    // identifier closed by an operator, a letter straight after a number,
    // a leading dot, the remaining operators, the letter and digit bounds,
    // high and zero bytes as separators, end of source with a word pending
    // and end of source with nothing pending
    add_text("12.5+ab9*7x.3-A/Z");
    add_item(CMD_CHAR, 8'h80);
    add_item(CMD_CHAR, 8'hFF);
    add_item(CMD_CHAR, 8'h00);
    add_text("z0");
    add_item(CMD_END, 8'hFF);
    add_item(CMD_END, 8'h00);

    // one long identifier closed by an operator, then end of source
    add_item(CMD_CHAR, random_char(PICK_LETTER));
    for (int i = 0; i < LONG_TAIL; i++)
      add_item(CMD_CHAR, random_char($urandom_range(0, 1) ? PICK_LETTER : PICK_DIGIT));
    add_item(CMD_CHAR, CH_PLUS);
    add_item(CMD_END, random_byte());

    // random: mostly well-formed words and operators run together, with
    // separators, stray bytes and the odd end of source in between
    base_n = source_chars.size();
    while (source_chars.size() - base_n < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          run_len = $urandom_range(1, 6);
          add_item(CMD_CHAR, random_char(PICK_DIGIT));
          for (int i = 1; i < run_len; i++)
            add_item(CMD_CHAR, ($urandom_range(0, 4) == 0) ? CH_DOT : random_char(PICK_DIGIT));
        end
        3, 4, 5: begin
          run_len = $urandom_range(1, 8);
          add_item(CMD_CHAR, random_char(PICK_LETTER));
          for (int i = 1; i < run_len; i++)
            add_item(CMD_CHAR, random_char($urandom_range(0, 2) ? PICK_LETTER : PICK_DIGIT));
        end
        6, 7: add_item(CMD_CHAR, random_char(PICK_OP));
        8: add_item(CMD_CHAR, ($urandom_range(0, 1) != 0) ? 8'h20 : random_byte());
        default: begin
          if ($urandom_range(0, 3) == 0)
            add_item(CMD_END, random_byte());
          else
            add_item(CMD_CHAR, random_byte());
        end
      endcase
    end
    add_item(CMD_END, random_byte());

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // everything offered and taken, then every predicted token seen
    while (source_chars.size() > 0 || chars_bus.valid)
      @(posedge clk);
    while (expected_tokens.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ct_pkg.sv
rtl/ct_char_if.sv
rtl/ct_queue.sv
rtl/ct_front.sv
rtl/ct_back.sv
rtl/char_stream_tokenizer_top.sv
rtl/ct_checker.sv
tb/sv/tb.sv
